[src/aidf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aidf_pkg: shared types and constants
// Field widths, opcode and status codes, and the command beat passed from the
// front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package aidf_pkg;

    localparam int CNT_W  = 7;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 3;
    localparam int MPOS_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 3'd0,
        OP_FIND    = 3'd1,
        OP_INSERT  = 3'd2,
        OP_DELETE  = 3'd3,
        OP_RESTORE = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_MATCH   = 3'd1,
        ST_NOMATCH = 3'd2,
        ST_BADPOS  = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CMD_REPORT,
        CMD_LOAD,
        CMD_FIND,
        CMD_INSERT,
        CMD_DELETE,
        CMD_RESTORE
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PASS,
        BK_FIND
    } back_state_t;

    typedef struct packed {
        cmd_kind_t               kind;
        status_t                 status;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        logic [CNT_W-1:0]        count;
        logic [CNT_W-1:0]        len;
    } cmd_t;

endpackage

[src/aidf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aidf_front: command classifier
// Tracks live and snapshot element counts, checks each item against them and
// turns it into a command for the back end.
// ----------------------------------------------------------------------------
module aidf_front import aidf_pkg::*;
#(
    parameter int CAPACITY
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [OP_W-1:0]         opcode,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    output cmd_t                    cmd
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] scount_reg;
    logic [CNT_W-1:0] scount_next;

    always_comb
    begin
        cmd         = '{kind: CMD_REPORT, status: ST_OK, pos: position, val: value,
                        count: count_reg, len: '0};
        count_next  = count_reg;
        scount_next = scount_reg;
        unique case (op_t'(opcode))
            OP_LOAD:
            begin
                if (count_reg >= CAP_CNT)
                begin
                    cmd.status = ST_FULL;
                end
                else
                begin
                    cmd.kind    = CMD_LOAD;
                    cmd.pos     = count_reg;
                    cmd.len     = CNT_W'(count_reg + 1'b1);
                    cmd.count   = CNT_W'(count_reg + 1'b1);
                    count_next  = CNT_W'(count_reg + 1'b1);
                    scount_next = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_FIND:
            begin
                cmd.kind = CMD_FIND;
                cmd.len  = count_reg;
            end
            OP_INSERT:
            begin
                if (position > count_reg)
                begin
                    cmd.status = ST_BADPOS;
                end
                else if (count_reg >= CAP_CNT)
                begin
                    cmd.status = ST_FULL;
                end
                else
                begin
                    cmd.kind    = CMD_INSERT;
                    cmd.len     = CNT_W'(count_reg + 1'b1);
                    cmd.count   = CNT_W'(count_reg + 1'b1);
                    count_next  = CNT_W'(count_reg + 1'b1);
                    scount_next = count_reg;
                end
            end
            OP_DELETE:
            begin
                if (position >= count_reg)
                begin
                    cmd.status = ST_BADPOS;
                end
                else
                begin
                    cmd.kind    = CMD_DELETE;
                    cmd.len     = CNT_W'(count_reg - 1'b1);
                    cmd.count   = CNT_W'(count_reg - 1'b1);
                    count_next  = CNT_W'(count_reg - 1'b1);
                    scount_next = count_reg;
                end
            end
            OP_RESTORE:
            begin
                cmd.kind   = CMD_RESTORE;
                cmd.len    = scount_reg;
                cmd.count  = scount_reg;
                count_next = scount_reg;
            end
            default:
            begin
                cmd.kind = CMD_REPORT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            scount_reg <= '0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            scount_reg <= scount_next;
        end
    end

endmodule

[src/aidf_cmdq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aidf_cmdq: two-entry command queue
// Decouples the classifier from the array engine so each can stall alone.
// ----------------------------------------------------------------------------
module aidf_cmdq import aidf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    input  logic pop,
    output cmd_t dout,
    output logic empty,
    output logic full
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign empty = (fill_reg == 2'd0);
    assign full  = (fill_reg == 2'd2);
    assign dout  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[src/aidf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aidf_back: array engine
// Holds the two array banks. Edits run as one copy pass from one bank into
// the other; insert and delete then swap which bank is live. Find scans the
// live bank and emits one result beat per match, or a single no-match beat.
// ----------------------------------------------------------------------------
module aidf_back import aidf_pkg::*;
#(
    parameter int CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  cmd_t                q_head,
    output logic                q_pop,
    output logic                strobe,
    output logic [STAT_W-1:0]   status,
    output logic [MPOS_W-1:0]   match_position,
    output logic [CNT_W-1:0]    element_count,
    output logic                last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic        pv_reg, pv_next;
    logic [AW-1:0] pidx_reg, pidx_next;
    logic        puse_reg, puse_next;
    logic        live_sel_reg, live_sel_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;

    logic        strobe_reg, strobe_next;
    status_t     status_reg, status_next;
    logic [MPOS_W-1:0] mpos_reg, mpos_next;
    logic [CNT_W-1:0]  ecount_reg, ecount_next;
    logic        last_reg, last_next;

    logic signed [VAL_W-1:0] bank_a [CAPACITY];
    logic signed [VAL_W-1:0] bank_b [CAPACITY];
    logic signed [VAL_W-1:0] a_rd_reg, b_rd_reg;

    logic [AW-1:0]  raddr;
    logic [CNT_W-1:0] raddr_full;
    logic           src_sel;
    logic           issue;
    logic           finish;
    logic signed [VAL_W-1:0] rdata;
    logic           we_a, we_b;
    logic [AW-1:0]  waddr;
    logic signed [VAL_W-1:0] wdata;

    assign strobe         = strobe_reg;
    assign status         = status_reg;
    assign match_position = mpos_reg;
    assign element_count  = ecount_reg;
    assign last           = last_reg;

    // restore copies snapshot into live; every other pass reads the live bank
    assign src_sel = (cmd_reg.kind == CMD_RESTORE) ? ~live_sel_reg : live_sel_reg;
    assign rdata   = src_sel ? b_rd_reg : a_rd_reg;
    assign issue   = (state_reg != BK_IDLE) && (j_reg < cmd_reg.len);
    assign finish  = (state_reg != BK_IDLE) && !issue && !pv_reg;

    always_comb
    begin
        case (cmd_reg.kind)
            CMD_INSERT:
                raddr_full = (j_reg > cmd_reg.pos) ? CNT_W'(j_reg - 1'b1) : j_reg;
            CMD_DELETE:
                raddr_full = (j_reg >= cmd_reg.pos) ? CNT_W'(j_reg + 1'b1) : j_reg;
            default:
                raddr_full = j_reg;
        endcase
        raddr = raddr_full[AW-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        j_next          = j_reg;
        pv_next         = 1'b0;
        pidx_next       = pidx_reg;
        puse_next       = puse_reg;
        live_sel_next   = live_sel_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        strobe_next     = 1'b0;
        status_next     = status_reg;
        mpos_next       = mpos_reg;
        ecount_next     = ecount_reg;
        last_next       = last_reg;
        q_pop           = 1'b0;
        we_a            = 1'b0;
        we_b            = 1'b0;
        waddr           = pidx_reg;
        wdata           = puse_reg ? cmd_reg.val : rdata;

        if (issue)
        begin
            pv_next   = 1'b1;
            pidx_next = j_reg[AW-1:0];
            puse_next = ((cmd_reg.kind == CMD_INSERT) || (cmd_reg.kind == CMD_LOAD))
                        && (j_reg == cmd_reg.pos);
            j_next    = CNT_W'(j_reg + 1'b1);
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    j_next   = '0;
                    case (q_head.kind)
                        CMD_REPORT:
                        begin
                            strobe_next = 1'b1;
                            status_next = q_head.status;
                            mpos_next   = '0;
                            ecount_next = q_head.count;
                            last_next   = 1'b1;
                        end
                        CMD_FIND:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = BK_FIND;
                        end
                        default:
                        begin
                            state_next = BK_PASS;
                        end
                    endcase
                    // append the loaded value to the live bank up front
                    if (q_head.kind == CMD_LOAD)
                    begin
                        waddr = q_head.pos[AW-1:0];
                        wdata = q_head.val;
                        we_a  = ~live_sel_reg;
                        we_b  = live_sel_reg;
                    end
                end
            end
            BK_PASS:
            begin
                if (pv_reg)
                begin
                    we_a = src_sel;
                    we_b = ~src_sel;
                end
                if (finish)
                begin
                    if ((cmd_reg.kind == CMD_INSERT) || (cmd_reg.kind == CMD_DELETE))
                    begin
                        live_sel_next = ~live_sel_reg;
                    end
                    strobe_next = 1'b1;
                    status_next = ST_OK;
                    mpos_next   = '0;
                    ecount_next = cmd_reg.count;
                    last_next   = 1'b1;
                    state_next  = BK_IDLE;
                end
            end
            BK_FIND:
            begin
                // hold one match back so the final beat can carry last
                if (pv_reg && (rdata == cmd_reg.val))
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        status_next = ST_MATCH;
                        mpos_next   = MPOS_W'(pend_idx_reg);
                        ecount_next = cmd_reg.count;
                        last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = pidx_reg;
                end
                if (finish)
                begin
                    strobe_next = 1'b1;
                    status_next = pend_valid_reg ? ST_MATCH : ST_NOMATCH;
                    mpos_next   = pend_valid_reg ? MPOS_W'(pend_idx_reg) : '0;
                    ecount_next = cmd_reg.count;
                    last_next   = 1'b1;
                    state_next  = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            j_reg          <= '0;
            pv_reg         <= 1'b0;
            live_sel_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            j_reg          <= j_next;
            pv_reg         <= pv_next;
            live_sel_reg   <= live_sel_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pidx_reg     <= pidx_next;
        puse_reg     <= puse_next;
        pend_idx_reg <= pend_idx_next;
        status_reg   <= status_next;
        mpos_reg     <= mpos_next;
        ecount_reg   <= ecount_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            bank_a[waddr] <= wdata;
        end
        a_rd_reg <= bank_a[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            bank_b[waddr] <= wdata;
        end
        b_rd_reg <= bank_b[raddr];
    end

endmodule

[src/array_insert_delete_find_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_insert_delete_find_engine: ordered array with snapshot and restore
// Keeps up to CAPACITY signed 32-bit elements in a live copy and a snapshot
// copy, with load, find, insert, delete and restore commands.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; a two-beat command
// queue lets a new command in while the array engine is still working, and
// busy rises only when that queue is full. Error and unused-opcode commands
// give a single report beat. Load, insert, delete and restore each run one
// copy pass between the two array banks at one element per cycle. Find scans
// the live elements at one per cycle and gives one result beat per match, the
// last one flagged, or a single no-match beat. Results appear for exactly one
// cycle with strobe high and cannot be held off, so the receiver must take
// every strobed beat.
// ----------------------------------------------------------------------------
module array_insert_delete_find_engine import aidf_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         opcode,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    output logic                    strobe,
    output logic [STAT_W-1:0]       status,
    output logic [MPOS_W-1:0]       match_position,
    output logic [CNT_W-1:0]        element_count,
    output logic                    last
);

    logic accept;
    cmd_t front_cmd;
    cmd_t q_head;
    logic q_empty;
    logic q_full;
    logic q_pop;

    assign busy   = q_full;
    assign accept = start && !q_full;

    aidf_front #(.CAPACITY(CAPACITY)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .opcode   (opcode),
        .position (position),
        .value    (value),
        .cmd      (front_cmd)
    );

    aidf_cmdq u_cmdq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (front_cmd),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty),
        .full  (q_full)
    );

    aidf_back #(.CAPACITY(CAPACITY)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .strobe         (strobe),
        .status         (status),
        .match_position (match_position),
        .element_count  (element_count),
        .last           (last)
    );

endmodule
